[rtl/tcdq_pkg.sv]
// Shared types and constants for the two-class task dispatch queue.
// No dependencies.
package tcdq_pkg;

    localparam logic [1:0] REQ_ADD      = 2'd0;
    localparam logic [1:0] REQ_DISPATCH = 2'd1;
    localparam logic [1:0] REQ_REMOVE   = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture request, clear result fields
        logic add;       // append to selected class
        logic scan_init; // start a sweep over a class
        logic scan_step; // process one entry of the sweep
        logic sel_fifo;  // class used by the sweep
        logic scan_max;  // sweep is a max search (else purge copy)
        logic drop;      // start compaction removing best index or FIFO head
        logic set_empty; // report nothing to dispatch
        logic set_full;  // report store full
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_done;
        logic prio_full;
        logic fifo_full;
        logic prio_empty;
        logic fifo_empty;
    } t_stat;

endpackage

[rtl/tcdq_ctrl.sv]
// Controller state machine for the two-class task dispatch queue.
// Depends on tcdq_pkg.
module tcdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic [1:0]       i_req,
    input  logic             i_fifo_class,
    input  tcdq_pkg::t_stat  i_stat,
    output tcdq_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_MAX, S_DROP, S_PURGE_P, S_PURGE_F, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_req;
    logic       r_fc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_req)
                    tcdq_pkg::REQ_ADD: begin
                        if (r_fc ? i_stat.fifo_full : i_stat.prio_full)
                            o_cmd.set_full = 1'b1;
                        else begin
                            o_cmd.add      = 1'b1;
                            o_cmd.sel_fifo = r_fc;
                        end
                        n_state = S_OUT;
                    end
                    tcdq_pkg::REQ_DISPATCH: begin
                        if (!i_stat.prio_empty) begin
                            o_cmd.scan_init = 1'b1;
                            o_cmd.scan_max  = 1'b1;
                            n_state = S_MAX;
                        end else if (!i_stat.fifo_empty) begin
                            o_cmd.drop     = 1'b1;
                            o_cmd.sel_fifo = 1'b1;
                            n_state = S_DROP;
                        end else begin
                            o_cmd.set_empty = 1'b1;
                            n_state = S_OUT;
                        end
                    end
                    tcdq_pkg::REQ_REMOVE: begin
                        o_cmd.scan_init = 1'b1;
                        n_state = S_PURGE_P;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_MAX: begin
                o_cmd.scan_max = 1'b1;
                if (i_stat.scan_done) begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_DROP;
                end else
                    o_cmd.scan_step = 1'b1;
            end
            S_DROP: begin
                o_cmd.sel_fifo = r_fc;
                if (i_stat.scan_done) n_state = S_OUT;
                else o_cmd.scan_step = 1'b1;
            end
            S_PURGE_P: begin
                if (i_stat.scan_done) begin
                    o_cmd.scan_init = 1'b1;
                    o_cmd.sel_fifo  = 1'b1;
                    n_state = S_PURGE_F;
                end else
                    o_cmd.scan_step = 1'b1;
            end
            S_PURGE_F: begin
                o_cmd.sel_fifo = 1'b1;
                if (i_stat.scan_done) n_state = S_OUT;
                else o_cmd.scan_step = 1'b1;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= '0;
            r_fc    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_req <= i_req;
                r_fc  <= i_fifo_class;
            end else if (r_state == S_DECODE && r_req == tcdq_pkg::REQ_DISPATCH)
                r_fc <= i_stat.prio_empty;
        end
    end

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.add, o_cmd.drop, o_cmd.set_full, o_cmd.set_empty}) <= 1)
        else $error("conflicting datapath commands");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result withdrawn while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("request loaded while busy");

endmodule

[rtl/tcdq_dp.sv]
// Datapath: both class stores, max search, compaction and result registers.
// Depends on tcdq_pkg.
module tcdq_dp #(
    parameter int CLASS_DEPTH = 16,
    parameter int TAG_BITS    = 16,
    parameter int LEVEL_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcdq_pkg::t_cmd        i_cmd,
    output tcdq_pkg::t_stat       o_stat,
    input  logic [TAG_BITS-1:0]   i_tag,
    input  logic [LEVEL_BITS-1:0] i_level,
    output logic [1:0]            o_status,
    output logic [15:0]           o_tag,
    output logic [7:0]            o_level,
    output logic                  o_fifo_class,
    output logic [5:0]            o_removed,
    output logic [5:0]            o_pending
);

    localparam int IW = $clog2(CLASS_DEPTH);
    localparam int CW = $clog2(CLASS_DEPTH + 1);

    // Stores are registers read one entry per cycle at a sweep index.
    logic [TAG_BITS-1:0]   r_ptag [CLASS_DEPTH];
    logic [LEVEL_BITS-1:0] r_plvl [CLASS_DEPTH];
    logic [TAG_BITS-1:0]   r_ftag [CLASS_DEPTH];
    logic [LEVEL_BITS-1:0] r_flvl [CLASS_DEPTH];
    logic [CW-1:0]         r_pused, r_fused;

    logic [TAG_BITS-1:0]   r_tag;
    logic [LEVEL_BITS-1:0] r_level;
    logic [CW-1:0]         r_rd, r_wr;   // sweep read and write positions
    logic                  r_sf;         // class being swept
    logic [IW-1:0]         r_best;
    logic [LEVEL_BITS-1:0] r_best_lvl;
    logic [TAG_BITS-1:0]   r_best_tag;
    logic [5:0]            r_removed;
    logic [1:0]            r_status;
    logic                  r_ofc, r_hit, r_drop;

    logic [CW-1:0]         used_sel;
    logic [TAG_BITS-1:0]   rd_tag;
    logic [LEVEL_BITS-1:0] rd_lvl;
    logic [IW-1:0]         rd_idx, wr_idx;

    assign used_sel = r_sf ? r_fused : r_pused;
    assign rd_idx   = r_rd[IW-1:0];
    assign wr_idx   = r_wr[IW-1:0];
    assign rd_tag   = r_sf ? r_ftag[rd_idx] : r_ptag[rd_idx];
    assign rd_lvl   = r_sf ? r_flvl[rd_idx] : r_plvl[rd_idx];

    assign o_stat.scan_done  = (r_rd >= used_sel);
    assign o_stat.prio_full  = (r_pused == CW'(CLASS_DEPTH));
    assign o_stat.fifo_full  = (r_fused == CW'(CLASS_DEPTH));
    assign o_stat.prio_empty = (r_pused == '0);
    assign o_stat.fifo_empty = (r_fused == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pused <= '0;
            r_fused <= '0;
        end else begin
            if (i_cmd.add) begin
                if (i_cmd.sel_fifo) r_fused <= r_fused + 1'b1;
                else r_pused <= r_pused + 1'b1;
            end
            // end of purge or drop sweep: commit kept count
            if (!i_cmd.scan_max && !i_cmd.scan_step && !i_cmd.drop &&
                o_stat.scan_done && (r_hit || r_drop)) begin
                if (r_sf) r_fused <= r_wr;
                else r_pused <= r_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag      <= i_tag;
            r_level    <= i_level;
            r_status   <= tcdq_pkg::ST_DONE;
            r_best_tag <= '0;
            r_best_lvl <= '0;
            r_ofc      <= 1'b0;
            r_removed  <= '0;
            r_hit      <= 1'b0;
            r_drop     <= 1'b0;
        end
        if (i_cmd.set_full)  r_status <= tcdq_pkg::ST_FULL;
        if (i_cmd.set_empty) r_status <= tcdq_pkg::ST_EMPTY;
        if (i_cmd.add) begin
            if (i_cmd.sel_fifo) begin
                r_ftag[r_fused[IW-1:0]] <= r_tag;
                r_flvl[r_fused[IW-1:0]] <= r_level;
            end else begin
                r_ptag[r_pused[IW-1:0]] <= r_tag;
                r_plvl[r_pused[IW-1:0]] <= r_level;
            end
        end
        if (i_cmd.scan_init) begin
            r_sf  <= i_cmd.sel_fifo;
            r_rd  <= '0;
            r_wr  <= '0;
            r_hit <= !i_cmd.scan_max;
            r_drop <= 1'b0;
            r_best <= '0;
        end else if (i_cmd.drop) begin
            // compaction from best (or head of FIFO) to end, one move a cycle;
            // the count drops when the sweep ends
            r_sf  <= i_cmd.sel_fifo;
            r_hit <= 1'b0;
            r_drop <= 1'b1;
            if (i_cmd.sel_fifo) begin
                r_best_tag <= r_ftag[0];
                r_best_lvl <= r_flvl[0];
                r_ofc      <= 1'b1;
                r_wr       <= '0;
                r_rd       <= CW'(1);
            end else begin
                r_wr <= CW'(r_best);
                r_rd <= CW'(r_best) + 1'b1;
            end
        end else if (i_cmd.scan_step) begin
            r_rd <= r_rd + 1'b1;
            if (i_cmd.scan_max) begin
                if (r_rd == '0 || rd_lvl > r_best_lvl) begin
                    r_best     <= rd_idx;
                    r_best_lvl <= rd_lvl;
                    r_best_tag <= rd_tag;
                end
            end else if (r_hit && rd_tag == r_tag) begin
                r_removed <= r_removed + 1'b1;
            end else begin
                if (r_sf) begin
                    r_ftag[wr_idx] <= rd_tag;
                    r_flvl[wr_idx] <= rd_lvl;
                end else begin
                    r_ptag[wr_idx] <= rd_tag;
                    r_plvl[wr_idx] <= rd_lvl;
                end
                r_wr <= r_wr + 1'b1;
            end
        end
    end

    assign o_status     = r_status;
    assign o_tag        = 16'(r_best_tag);
    assign o_level      = 8'(r_best_lvl);
    assign o_fifo_class = r_ofc;
    assign o_removed    = r_removed;
    assign o_pending    = 6'(r_pused + r_fused);

    a_pcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pused <= CW'(CLASS_DEPTH))
        else $error("priority count overflow");
    a_fcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fused <= CW'(CLASS_DEPTH))
        else $error("fifo count overflow");
    a_wr_le_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> r_wr <= r_rd)
        else $error("compaction write passed read");

endmodule

[rtl/two_class_task_dispatch_queue_top.sv]
// Top level of the two-class task dispatch queue.
// Depends on tcdq_pkg, tcdq_ctrl and tcdq_dp.
//
// Requests enter on s_axis; each gives exactly one result on m_axis.
// s_axis_tdata (low bit up): req_type[1:0], task_tag[15:0], task_priority[7:0],
// fifo_class; m_axis_tdata: status[1:0], out_tag[15:0], out_priority[7:0],
// out_fifo_class, removed_count[5:0], pending_count[5:0].
// One request is handled at a time. Add, empty dispatch and unused codes go from the
// decode state straight to the result; priority dispatch sweeps all priority entries
// for the highest level, then moves each entry behind the winner up one place;
// FIFO dispatch moves each entry behind the head up one place; remove sweeps
// the priority class, then the FIFO class, one entry a cycle. The single-ported
// sweep over the stores sets the time per request. The result holds while
// m_axis_tready is low and no new request is taken until it is transferred. Reset empties both classes.
module two_class_task_dispatch_queue_top #(
    parameter int CLASS_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // req_type, task_tag, task_priority, fifo_class
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // status, out_tag, out_priority, out_fifo_class,
                                       // removed_count, pending_count
);

    tcdq_pkg::t_cmd  cmd;
    tcdq_pkg::t_stat stat;
    logic [1:0]  status;
    logic [15:0] otag;
    logic [7:0]  olvl;
    logic        ofc;
    logic [5:0]  removed, pending;

    tcdq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_req        (s_axis_tdata[1:0]),
        .i_fifo_class (s_axis_tdata[26]),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    tcdq_dp #(
        .CLASS_DEPTH (CLASS_DEPTH),
        .TAG_BITS    (16),
        .LEVEL_BITS  (8)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_tag        (s_axis_tdata[17:2]),
        .i_level      (s_axis_tdata[25:18]),
        .o_status     (status),
        .o_tag        (otag),
        .o_level      (olvl),
        .o_fifo_class (ofc),
        .o_removed    (removed),
        .o_pending    (pending)
    );

    assign m_axis_tdata = {1'b0, pending, removed, ofc, olvl, otag, status};

endmodule

[tb/tb_two_class_task_dispatch_queue_top.sv]
// Testbench for the two-class task dispatch queue: random and directed requests
// checked against a behavioral model of both task stores.
// Depends on tcdq_pkg and two_class_task_dispatch_queue_top.
`timescale 1ns / 100ps

module tb_two_class_task_dispatch_queue_top;

    localparam int DEPTH = 16;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic       fifo_class;
        logic [7:0] prio;
        logic [15:0] tag;
        logic [1:0] req;
    } t_req;

    typedef struct packed {
        logic [5:0]  pending;
        logic [5:0]  removed;
        logic        from_fifo;
        logic [7:0]  prio;
        logic [15:0] tag;
        logic [1:0]  status;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    t_req req_queue[$];
    t_res expected_q[$];
    int   fail_count = 0;
    bit   stim_done = 1'b0;
    bit   hold_off = 1'b0;
    bit   in_taken = 1'b0;
    bit   out_taken = 1'b0;

    // scoreboard copy of the two stores
    logic [15:0] pq_tag[$];
    logic [7:0]  pq_lvl[$];
    logic [15:0] fq_tag[$];
    logic [7:0]  fq_lvl[$];

    two_class_task_dispatch_queue_top #(.CLASS_DEPTH(DEPTH)) dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic t_res apply_request(t_req r);
        t_res o;
        int   best;
        int   n;
        o = '0;
        case (r.req)
            tcdq_pkg::REQ_ADD: begin
                if (r.fifo_class) begin
                    if (fq_tag.size() >= DEPTH) o.status = tcdq_pkg::ST_FULL;
                    else begin
                        fq_tag.insert(fq_tag.size(), r.tag);
                        fq_lvl.insert(fq_lvl.size(), r.prio);
                    end
                end else begin
                    if (pq_tag.size() >= DEPTH) o.status = tcdq_pkg::ST_FULL;
                    else begin
                        pq_tag.insert(pq_tag.size(), r.tag);
                        pq_lvl.insert(pq_lvl.size(), r.prio);
                    end
                end
            end
            tcdq_pkg::REQ_DISPATCH: begin
                if (pq_tag.size() > 0) begin
                    best = 0;
                    for (int i = 1; i < pq_tag.size(); i++)
                        if (pq_lvl[i] > pq_lvl[best]) best = i;
                    o.tag = pq_tag[best];
                    o.prio = pq_lvl[best];
                    pq_tag.delete(best);
                    pq_lvl.delete(best);
                end else if (fq_tag.size() > 0) begin
                    o.tag = fq_tag[0];
                    o.prio = fq_lvl[0];
                    fq_tag.delete(0);
                    fq_lvl.delete(0);
                    o.from_fifo = 1'b1;
                end else begin
                    o.status = tcdq_pkg::ST_EMPTY;
                end
            end
            tcdq_pkg::REQ_REMOVE: begin
                n = 0;
                for (int i = pq_tag.size() - 1; i >= 0; i--)
                    if (pq_tag[i] == r.tag) begin
                        pq_tag.delete(i);
                        pq_lvl.delete(i);
                        n++;
                    end
                for (int i = fq_tag.size() - 1; i >= 0; i--)
                    if (fq_tag[i] == r.tag) begin
                        fq_tag.delete(i);
                        fq_lvl.delete(i);
                        n++;
                    end
                o.removed = 6'(n);
            end
            default: ;
        endcase
        o.pending = 6'(pq_tag.size() + fq_tag.size());
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // input transfers are recorded at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_q.insert(expected_q.size(), apply_request(t_req'(s_axis_tdata[26:0])));
            in_taken = 1'b1;
        end
    end

    // driver
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken || !s_axis_tvalid) begin
                if (in_taken) begin
                    in_taken = 1'b0;
                    send_gap = $urandom_range(0, 8);
                    if ($urandom_range(0, 3) == 0) send_gap = 0;
                end
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_queue.size() > 0) begin
                    s_axis_tdata <= {5'b0, req_queue[0]};
                    req_queue.delete(0);
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    stim_done = 1'b1;
                end
            end
        end
    end

    // receiver stall
    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (out_taken) begin
                out_taken = 1'b0;
                recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off partway through, counted here
    initial begin
        repeat (2000) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // monitor
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            out_taken = 1'b1;
            got = t_res'(m_axis_tdata);
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_q[0];
                expected_q.delete(0);
                if (got.status !== want.status) report_mismatch("status", got.status, want.status);
                if (got.tag !== want.tag) report_mismatch("out_tag", got.tag, want.tag);
                if (got.prio !== want.prio) report_mismatch("out_priority", got.prio, want.prio);
                if (got.from_fifo !== want.from_fifo)
                    report_mismatch("out_fifo_class", got.from_fifo, want.from_fifo);
                if (got.removed !== want.removed)
                    report_mismatch("removed_count", got.removed, want.removed);
                if (got.pending !== want.pending)
                    report_mismatch("pending_count", got.pending, want.pending);
            end
        end
    end

    function automatic t_req mk(logic [1:0] rq, logic [15:0] tg, logic [7:0] pr, logic fc);
        t_req r;
        r.req = rq;
        r.tag = tg;
        r.prio = pr;
        r.fifo_class = fc;
        return r;
    endfunction

    task automatic add_item(t_req r);
        req_queue.insert(req_queue.size(), r);
    endtask

    initial begin
        t_req r;
        int   k;
        // directed: empty dispatch, extremes, ties, full classes, removes, unused code
        add_item(mk(tcdq_pkg::REQ_DISPATCH, 16'hFFFF, 8'hFF, 1'b1));
        add_item(mk(REQ_UNUSED, 16'hFFFF, 8'hFF, 1'b1));
        add_item(mk(tcdq_pkg::REQ_ADD, 16'h0000, 8'h00, 1'b0));
        add_item(mk(tcdq_pkg::REQ_ADD, 16'hFFFF, 8'hFF, 1'b0));
        add_item(mk(tcdq_pkg::REQ_ADD, 16'h1234, 8'hFF, 1'b0));
        add_item(mk(tcdq_pkg::REQ_ADD, 16'hFFFF, 8'h80, 1'b1));
        add_item(mk(tcdq_pkg::REQ_DISPATCH, '0, '0, 1'b0));
        add_item(mk(tcdq_pkg::REQ_DISPATCH, '0, '0, 1'b0));
        add_item(mk(tcdq_pkg::REQ_REMOVE, 16'h5555, '0, 1'b0));
        add_item(mk(tcdq_pkg::REQ_REMOVE, 16'hFFFF, '0, 1'b0));
        for (int i = 0; i < 17; i++)
            add_item(mk(tcdq_pkg::REQ_ADD, 16'(i[1:0]), i[7:0], 1'b1));
        for (int i = 0; i < 17; i++)
            add_item(mk(tcdq_pkg::REQ_ADD, 16'(i[0]), 8'(i * 7), 1'b0));
        add_item(mk(tcdq_pkg::REQ_REMOVE, 16'h0000, '0, 1'b0));
        add_item(mk(tcdq_pkg::REQ_REMOVE, 16'h0001, '0, 1'b0));
        for (int i = 0; i < 6; i++) add_item(mk(tcdq_pkg::REQ_DISPATCH, '0, '0, 1'b0));
        // random: small tag pool so removes hit, with some full-range tags
        for (int i = 0; i < 350; i++) begin
            k = $urandom_range(0, 99);
            r.req = k < 45 ? tcdq_pkg::REQ_ADD : k < 80 ? tcdq_pkg::REQ_DISPATCH :
                    k < 97 ? tcdq_pkg::REQ_REMOVE : REQ_UNUSED;
            r.tag = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 7));
            r.prio = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3));
            r.fifo_class = 1'($urandom_range(0, 1));
            add_item(r);
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        wait (stim_done && expected_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
rtl/tcdq_pkg.sv
rtl/tcdq_ctrl.sv
rtl/tcdq_dp.sv
rtl/two_class_task_dispatch_queue_top.sv
tb/tb_two_class_task_dispatch_queue_top.sv
